// ===== sv/bfd_pkg.sv =====
// Package with sizes, register indexes and sequencer states of the bilinear fit downscaler.
`timescale 1ns / 1ps
package bfd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_W   = 12;
    localparam int PIX_W   = 32;
    localparam int ODATA_W = 80;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMIT_WIDTH   = 2'd2;
    localparam logic [1:0] REG_LIMIT_HEIGHT  = 2'd3;

    typedef enum logic [18:0] {
        ST_IDLE = 19'h00001,
        ST_RD   = 19'h00002,
        ST_BYP  = 19'h00004,
        ST_ROWM = 19'h00008,
        ST_ROWD = 19'h00010,
        ST_COLM = 19'h00020,
        ST_COLD = 19'h00040,
        ST_WD   = 19'h00080,
        ST_WGT  = 19'h00100,
        ST_ACC  = 19'h00200,
        ST_CHD  = 19'h00400,
        ST_EMIT = 19'h00800,
        ST_FIN  = 19'h01000,
        ST_RCA  = 19'h02000,
        ST_RCB  = 19'h04000,
        ST_RCC  = 19'h08000,
        ST_RCW  = 19'h10000,
        ST_RCD  = 19'h20000,
        ST_RCH  = 19'h40000
    } state_t;

endpackage

// ===== sv/bfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/bilinear_fit_downscaler_top.sv =====
// Top level of the bilinear fit downscaler: sequencer, shared multiplier and divider, row store.
`timescale 1ns / 1ps
//
//   Channel | Ports                    | Word contents (lowest bit first)
//   --------+--------------------------+-------------------------------------------------
//   config  | cfg_we cfg_index cfg_wdata | one 12-bit register per write, no read-back
//   input   | s_tvalid s_tready s_tdata | blue, green, red, alpha (8 bits each)
//   output  | m_tvalid m_tready m_tdata | blue, green, red, alpha, column(11), row(11),
//           | m_tlast m_tuser          | width(12), height(12); tlast=run end, tuser=frame end
//
// A scaled input word needs one pass of the shared radix-2 divider per coordinate it maps,
// plus four channel divisions on the same divider per output word it produces, so the
// divider sets the rate. A configuration write triggers a size recompute during which no
// input word is accepted. Reset is synchronous and active low; the row store needs no
// clearing. The last output word of an input waits in the output register while the next
// input is taken; an earlier one stalls the sequencer until the register is free.
module bilinear_fit_downscaler_top
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0: blue_in, green_in, red_in, alpha_in.
    input  logic [bfd_pkg::PIX_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // Fields from bit 0: blue_out, green_out, red_out, alpha_out, column_out, row_out,
    // scaled_width, scaled_height, then two zero pad bits.
    output logic [bfd_pkg::ODATA_W-1:0] m_tdata,
    output logic                        m_tlast,
    // Fields from bit 0: frame_end.
    output logic [0:0]                  m_tuser
);
    localparam int AW = $clog2(MAX_WIDTH);

    // Configuration and derived size.
    logic [11:0] src_w_reg, src_h_reg, lim_w_reg, lim_h_reg;
    logic [11:0] nw_reg, nw_next, nh_reg, nh_next;
    logic        byp_reg, byp_next;
    logic [11:0] w_eff, h_eff, lw, lh;

    // Frame position.
    logic [11:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [11:0] ncol_reg, ncol_next, nrow_reg, nrow_next;
    logic [31:0] left_reg, left_next, ul_reg, ul_next;

    state_t      state_reg, state_next;

    // Per-word working registers.
    logic [31:0] pix_reg, pix_next, up_reg, up_next;
    logic [11:0] sc_reg, sc_next, sr_reg, sr_next;
    logic        rlast_reg, rlast_next, flast_reg, flast_next;
    logic [1:0]  idx_reg, idx_next, nrows_reg, nrows_next, ncols_reg, ncols_next;
    logic [11:0] rows_reg [2], rows_next [2], rlo_reg [2], rlo_next [2];
    logic [11:0] rrem_reg [2], rrem_next [2];
    logic [11:0] cols_reg [2], cols_next [2], clo_reg [2], clo_next [2];
    logic [11:0] crem_reg [2], crem_next [2];
    logic        pi_reg, pi_next, pj_reg, pj_next;
    logic [1:0]  k_reg, k_next, ch_reg, ch_next;
    logic [22:0] wgt_reg [4], wgt_next [4];
    logic [22:0] d_reg, d_next;
    logic [30:0] acc_reg, acc_next;
    logic [7:0]  chan_reg [4], chan_next [4];
    logic [23:0] t1_reg, t1_next;
    logic [11:0] num_reg, num_next, den_reg, den_next;

    // Output register.
    logic        mv_reg, mv_next;
    logic [79:0] md_reg, md_next;
    logic        ml_reg, ml_next, mu_reg, mu_next;

    // Shared multiplier and divider.
    logic [23:0] mul_a, mul_b;
    logic [47:0] mul_p;
    logic        div_start;
    logic [31:0] div_dvd;
    logic [23:0] div_dsr;
    logic [24:0] div_rem_reg, div_rem_next;
    logic [31:0] div_quo_reg, div_quo_next;
    logic [23:0] div_dsr_reg, div_dsr_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic [24:0] div_sh;
    logic        div_ge;

    // Row store.
    logic        ram_we;
    logic [11:0] scl;
    logic [31:0] ram_rdata;

    // Local helpers.
    logic [12:0] r_idx, lo1, hi;
    logic        out_free, xsame, ysame;
    logic [31:0] v00, v01, v10, v11, vsel;
    logic [11:0] rx, ry;
    logic [30:0] acc_sum;

    assign w_eff = (src_w_reg == 12'd0) ? 12'd1 :
                   ({2'b00, src_w_reg} > 14'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : src_w_reg;
    assign h_eff = (src_h_reg == 12'd0) ? 12'd1 :
                   ({2'b00, src_h_reg} > 14'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : src_h_reg;
    assign lw = (lim_w_reg != 12'd0) ? lim_w_reg : w_eff;
    assign lh = (lim_h_reg != 12'd0) ? lim_h_reg : h_eff;
    assign scl = (scol_reg < w_eff) ? scol_reg : w_eff - 12'd1;

    assign mul_p = mul_a * mul_b;

    assign div_sh = {div_rem_reg[23:0], div_quo_reg[31]};
    assign div_ge = div_sh >= {1'b0, div_dsr_reg};

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    // Neighbor selection for the current output pair, as the blend corners.
    assign rx    = crem_reg[pj_reg];
    assign ry    = rrem_reg[pi_reg];
    assign xsame = (clo_reg[pj_reg] == sc_reg);
    assign ysame = (rlo_reg[pi_reg] == sr_reg);
    assign v11   = pix_reg;
    assign v10   = xsame ? pix_reg : left_reg;
    assign v01   = ysame ? pix_reg : up_reg;
    assign v00   = ysame ? v10 : (xsame ? up_reg : ul_reg);
    assign acc_sum = acc_reg + mul_p[30:0];

    always_comb begin
        case (k_reg)
            2'd0:    vsel = v00;
            2'd1:    vsel = v01;
            2'd2:    vsel = v10;
            default: vsel = v11;
        endcase
    end

    bfd_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_row_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(AW'(sc_reg)),
        .wdata(pix_reg),
        .raddr(AW'(scl)),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        nw_next = nw_reg; nh_next = nh_reg; byp_next = byp_reg;
        scol_next = scol_reg; srow_next = srow_reg;
        ncol_next = ncol_reg; nrow_next = nrow_reg;
        left_next = left_reg; ul_next = ul_reg;
        pix_next = pix_reg; up_next = up_reg; sc_next = sc_reg; sr_next = sr_reg;
        rlast_next = rlast_reg; flast_next = flast_reg;
        idx_next = idx_reg; nrows_next = nrows_reg; ncols_next = ncols_reg;
        rows_next = rows_reg; rlo_next = rlo_reg; rrem_next = rrem_reg;
        cols_next = cols_reg; clo_next = clo_reg; crem_next = crem_reg;
        pi_next = pi_reg; pj_next = pj_reg; k_next = k_reg; ch_next = ch_reg;
        wgt_next = wgt_reg; d_next = d_reg; acc_next = acc_reg; chan_next = chan_reg;
        t1_next = t1_reg; num_next = num_reg; den_next = den_reg;
        mv_next = (mv_reg && m_tready) ? 1'b0 : mv_reg;
        md_next = md_reg; ml_next = ml_reg; mu_next = mu_reg;
        mul_a = 24'd0; mul_b = 24'd0;
        div_start = 1'b0; div_dvd = 32'd0; div_dsr = 24'd0;
        ram_we = 1'b0;
        r_idx = 13'd0; lo1 = 13'd0; hi = 13'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pix_next   = s_tdata;
                    sc_next    = scl;
                    sr_next    = (srow_reg < h_eff) ? srow_reg : h_eff - 12'd1;
                    rlast_next = ({1'b0, scl} + 13'd1) >= {1'b0, w_eff};
                    flast_next = (({1'b0, scl} + 13'd1) >= {1'b0, w_eff}) &&
                                 (({1'b0, sr_next} + 13'd1) >= {1'b0, h_eff});
                    nrows_next = 2'd0;
                    ncols_next = 2'd0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                up_next    = ram_rdata;
                idx_next   = 2'd0;
                state_next = byp_reg ? ST_BYP : ST_ROWM;
            end
            ST_BYP: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {2'b00, h_eff, w_eff, sr_reg[10:0], sc_reg[10:0], pix_reg};
                    ml_next = 1'b1;
                    mu_next = flast_reg;
                    state_next = ST_FIN;
                end
            end
            ST_ROWM: begin
                r_idx = {1'b0, nrow_reg} + {11'd0, idx_reg};
                if (idx_reg == 2'd2 || r_idx >= {1'b0, nh_reg}) begin
                    idx_next   = 2'd0;
                    state_next = ST_COLM;
                end else begin
                    mul_a      = {12'd0, r_idx[11:0]};
                    mul_b      = {12'd0, h_eff};
                    div_start  = 1'b1;
                    div_dvd    = {8'd0, mul_p[23:0]};
                    div_dsr    = {12'd0, nh_reg};
                    state_next = ST_ROWD;
                end
            end
            ST_ROWD: begin
                if (div_cnt_reg == 6'd0) begin
                    r_idx = {1'b0, nrow_reg} + {11'd0, idx_reg};
                    lo1 = div_quo_reg[12:0] + 13'd1;
                    hi  = (lo1 < {1'b0, h_eff}) ? lo1 : {1'b0, h_eff} - 13'd1;
                    if (hi != {1'b0, sr_reg}) begin
                        idx_next   = 2'd0;
                        state_next = ST_COLM;
                    end else begin
                        rows_next[nrows_reg[0]] = r_idx[11:0];
                        rlo_next[nrows_reg[0]]  = div_quo_reg[11:0];
                        rrem_next[nrows_reg[0]] = div_rem_reg[11:0];
                        nrows_next = nrows_reg + 2'd1;
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_ROWM;
                    end
                end
            end
            ST_COLM: begin
                r_idx = {1'b0, ncol_reg} + {11'd0, idx_reg};
                if (idx_reg == 2'd2 || r_idx >= {1'b0, nw_reg}) begin
                    pi_next = 1'b0;
                    pj_next = 1'b0;
                    state_next = (nrows_reg == 2'd0 || ncols_reg == 2'd0) ? ST_FIN : ST_WD;
                end else begin
                    mul_a      = {12'd0, r_idx[11:0]};
                    mul_b      = {12'd0, w_eff};
                    div_start  = 1'b1;
                    div_dvd    = {8'd0, mul_p[23:0]};
                    div_dsr    = {12'd0, nw_reg};
                    state_next = ST_COLD;
                end
            end
            ST_COLD: begin
                if (div_cnt_reg == 6'd0) begin
                    r_idx = {1'b0, ncol_reg} + {11'd0, idx_reg};
                    lo1 = div_quo_reg[12:0] + 13'd1;
                    hi  = (lo1 < {1'b0, w_eff}) ? lo1 : {1'b0, w_eff} - 13'd1;
                    if (hi != {1'b0, sc_reg}) begin
                        pi_next = 1'b0;
                        pj_next = 1'b0;
                        state_next = (nrows_reg == 2'd0 || ncols_reg == 2'd0) ? ST_FIN : ST_WD;
                    end else begin
                        cols_next[ncols_reg[0]] = r_idx[11:0];
                        clo_next[ncols_reg[0]]  = div_quo_reg[11:0];
                        crem_next[ncols_reg[0]] = div_rem_reg[11:0];
                        ncols_next = ncols_reg + 2'd1;
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_COLM;
                    end
                end
            end
            ST_WD: begin
                mul_a  = {12'd0, nw_reg};
                mul_b  = {12'd0, nh_reg};
                d_next = mul_p[22:0];
                k_next = 2'd0;
                state_next = ST_WGT;
            end
            ST_WGT: begin
                // Weight k: bit 0 picks the column remainder, bit 1 the row remainder.
                mul_a = {12'd0, k_reg[0] ? rx : nw_reg - rx};
                mul_b = {12'd0, k_reg[1] ? ry : nh_reg - ry};
                wgt_next[k_reg] = mul_p[22:0];
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    ch_next  = 2'd0;
                    acc_next = 31'd0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                mul_a    = {16'd0, vsel[{ch_reg, 3'b000} +: 8]};
                mul_b    = {1'b0, wgt_reg[k_reg]};
                acc_next = acc_sum;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    div_start  = 1'b1;
                    div_dvd    = {acc_sum, 1'b0} + {9'd0, d_reg};
                    div_dsr    = {d_reg, 1'b0};
                    state_next = ST_CHD;
                end
            end
            ST_CHD: begin
                if (div_cnt_reg == 6'd0) begin
                    chan_next[ch_reg] = (div_quo_reg > 32'd255) ? 8'hFF : div_quo_reg[7:0];
                    k_next   = 2'd0;
                    acc_next = 31'd0;
                    ch_next  = ch_reg + 2'd1;
                    state_next = (ch_reg == 2'd3) ? ST_EMIT : ST_ACC;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {2'b00, nh_reg, nw_reg, rows_reg[pi_reg][10:0],
                               cols_reg[pj_reg][10:0], chan_reg[3], chan_reg[2],
                               chan_reg[1], chan_reg[0]};
                    ml_next = ({1'b0, pi_reg} == nrows_reg - 2'd1) &&
                              ({1'b0, pj_reg} == ncols_reg - 2'd1);
                    mu_next = (rows_reg[pi_reg] + 12'd1 == nh_reg) &&
                              (cols_reg[pj_reg] + 12'd1 == nw_reg);
                    k_next = 2'd0;
                    if ({1'b0, pj_reg} + 2'd1 < ncols_reg) begin
                        pj_next    = 1'b1;
                        state_next = ST_WGT;
                    end else if ({1'b0, pi_reg} + 2'd1 < nrows_reg) begin
                        pi_next    = 1'b1;
                        pj_next    = 1'b0;
                        state_next = ST_WGT;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                ram_we    = 1'b1;
                ul_next   = up_reg;
                left_next = pix_reg;
                ncol_next = ncol_reg + {10'd0, ncols_reg};
                if (rlast_reg) begin
                    scol_next = 12'd0;
                    ncol_next = 12'd0;
                    nrow_next = nrow_reg + {10'd0, nrows_reg};
                    if (flast_reg) begin
                        srow_next = 12'd0;
                        nrow_next = 12'd0;
                        left_next = 32'd0;
                        ul_next   = 32'd0;
                    end else begin
                        srow_next = sr_reg + 12'd1;
                    end
                end else begin
                    scol_next = sc_reg + 12'd1;
                    srow_next = sr_reg;
                end
                state_next = ST_IDLE;
            end
            ST_RCA: begin
                mul_a   = {12'd0, lw};
                mul_b   = {12'd0, h_eff};
                t1_next = mul_p[23:0];
                state_next = ST_RCB;
            end
            ST_RCB: begin
                // Pick the tighter axis: lw/w against lh/h by cross products.
                mul_a = {12'd0, lh};
                mul_b = {12'd0, w_eff};
                if (t1_reg <= mul_p[23:0]) begin
                    num_next = lw;
                    den_next = w_eff;
                end else begin
                    num_next = lh;
                    den_next = h_eff;
                end
                if ((lim_w_reg == 12'd0 && lim_h_reg == 12'd0) || num_next >= den_next) begin
                    byp_next = 1'b1;
                    nw_next  = w_eff;
                    nh_next  = h_eff;
                    state_next = ST_IDLE;
                end else begin
                    byp_next = 1'b0;
                    state_next = ST_RCC;
                end
            end
            ST_RCC: begin
                mul_a      = {12'd0, w_eff};
                mul_b      = {12'd0, num_reg};
                div_start  = 1'b1;
                div_dvd    = {7'd0, mul_p[23:0], 1'b0} + {20'd0, den_reg};
                div_dsr    = {11'd0, den_reg, 1'b0};
                state_next = ST_RCW;
            end
            ST_RCW: begin
                if (div_cnt_reg == 6'd0) begin
                    nw_next = (div_quo_reg[11:0] == 12'd0) ? 12'd1 : div_quo_reg[11:0];
                    state_next = ST_RCD;
                end
            end
            ST_RCD: begin
                mul_a      = {12'd0, h_eff};
                mul_b      = {12'd0, num_reg};
                div_start  = 1'b1;
                div_dvd    = {7'd0, mul_p[23:0], 1'b0} + {20'd0, den_reg};
                div_dsr    = {11'd0, den_reg, 1'b0};
                state_next = ST_RCH;
            end
            ST_RCH: begin
                if (div_cnt_reg == 6'd0) begin
                    nh_next = (div_quo_reg[11:0] == 12'd0) ? 12'd1 : div_quo_reg[11:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the frame and recomputes the output size.
        if (cfg_we) begin
            scol_next = 12'd0; srow_next = 12'd0;
            ncol_next = 12'd0; nrow_next = 12'd0;
            left_next = 32'd0; ul_next = 32'd0;
            state_next = ST_RCA;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb begin
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_dsr_next = div_dsr_reg;
        div_cnt_next = div_cnt_reg;
        if (div_start) begin
            div_rem_next = 25'd0;
            div_quo_next = div_dvd;
            div_dsr_next = div_dsr;
            div_cnt_next = 6'd32;
        end else if (div_cnt_reg != 6'd0) begin
            div_rem_next = div_ge ? div_sh - {1'b0, div_dsr_reg} : div_sh;
            div_quo_next = {div_quo_reg[30:0], div_ge};
            div_cnt_next = div_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            src_w_reg <= 12'd1; src_h_reg <= 12'd1;
            lim_w_reg <= 12'd0; lim_h_reg <= 12'd0;
            nw_reg <= 12'd1; nh_reg <= 12'd1; byp_reg <= 1'b1;
            scol_reg <= 12'd0; srow_reg <= 12'd0;
            ncol_reg <= 12'd0; nrow_reg <= 12'd0;
            left_reg <= 32'd0; ul_reg <= 32'd0;
            mv_reg <= 1'b0;
            div_cnt_reg <= 6'd0;
        end else begin
            state_reg <= state_next;
            nw_reg <= nw_next; nh_reg <= nh_next; byp_reg <= byp_next;
            scol_reg <= scol_next; srow_reg <= srow_next;
            ncol_reg <= ncol_next; nrow_reg <= nrow_next;
            left_reg <= left_next; ul_reg <= ul_next;
            mv_reg <= mv_next;
            div_cnt_reg <= div_cnt_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w_reg <= cfg_wdata;
                    REG_SOURCE_HEIGHT: src_h_reg <= cfg_wdata;
                    REG_LIMIT_WIDTH:   lim_w_reg <= cfg_wdata;
                    REG_LIMIT_HEIGHT:  lim_h_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next; up_reg <= up_next; sc_reg <= sc_next; sr_reg <= sr_next;
        rlast_reg <= rlast_next; flast_reg <= flast_next;
        idx_reg <= idx_next; nrows_reg <= nrows_next; ncols_reg <= ncols_next;
        rows_reg <= rows_next; rlo_reg <= rlo_next; rrem_reg <= rrem_next;
        cols_reg <= cols_next; clo_reg <= clo_next; crem_reg <= crem_next;
        pi_reg <= pi_next; pj_reg <= pj_next; k_reg <= k_next; ch_reg <= ch_next;
        wgt_reg <= wgt_next; d_reg <= d_next; acc_reg <= acc_next; chan_reg <= chan_next;
        t1_reg <= t1_next; num_reg <= num_next; den_reg <= den_next;
        md_reg <= md_next; ml_reg <= ml_next; mu_reg <= mu_next;
        div_rem_reg <= div_rem_next; div_quo_reg <= div_quo_next; div_dsr_reg <= div_dsr_next;
    end
endmodule
